// ===== hw/rtl/wavp_pkg.sv =====
// Shared item codes and result types for the WAV header stream parser.
`default_nettype none

package wavp_pkg;

    localparam logic [3:0] KIND_RIFF_SIZE  = 4'd0;
    localparam logic [3:0] KIND_FORMAT     = 4'd1;
    localparam logic [3:0] KIND_CHANNELS   = 4'd2;
    localparam logic [3:0] KIND_RATE       = 4'd3;
    localparam logic [3:0] KIND_BYTE_RATE  = 4'd4;
    localparam logic [3:0] KIND_BLOCK_ALGN = 4'd5;
    localparam logic [3:0] KIND_BITS       = 4'd6;
    localparam logic [3:0] KIND_LIST_SIZE  = 4'd7;
    localparam logic [3:0] KIND_DATA_SIZE  = 4'd8;
    localparam logic [3:0] KIND_SAMPLE     = 4'd9;

    typedef struct packed {
        logic [3:0]  item_kind;
        logic [31:0] item_value;
        logic        last_sample;
    } item_t;

    typedef struct packed {
        logic  emit;
        item_t item;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wavp_byte_if.sv =====
// Valid/ready channel carrying one byte of the WAV stream per request.
`default_nettype none

interface wavp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;

    modport source (output valid, output file_byte, input ready);
    modport sink   (input valid, input file_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wavp_item_if.sv =====
// Valid/ready channel carrying one parsed header field or sample byte per request.
`default_nettype none

interface wavp_item_if;
    logic        valid;
    logic        ready;
    logic [3:0]  item_kind;
    logic [31:0] item_value;
    logic        last_sample;

    modport source (output valid, output item_kind, output item_value, output last_sample,
                    input ready);
    modport sink   (input valid, input item_kind, input item_value, input last_sample,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wavp_in_stage.sv =====
// Input register holding one accepted stream byte until the parser consumes it.
`default_nettype none

module wavp_in_stage (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wavp_byte_if.sink   bytes,
    input  wire logic   advance,
    output logic        byte_valid,
    output logic [7:0]  byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // A held byte leaves whenever the downstream side advances, so a new
    // request can be taken in the same cycle.
    assign bytes.ready = !valid_reg || advance;
    assign valid_next  = bytes.valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            data_reg <= bytes.file_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;
endmodule

`default_nettype wire

// ===== hw/rtl/wavp_parser.sv =====
// Parse state machine: tracks the stage, byte position, shift word and remaining count.
`default_nettype none

module wavp_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  byte_data,
    output wavp_pkg::result_t result
);
    import wavp_pkg::*;

    localparam logic [2:0] ST_RIFF  = 3'd0;
    localparam logic [2:0] ST_FMT   = 3'd1;
    localparam logic [2:0] ST_TAG   = 3'd2;
    localparam logic [2:0] ST_LSIZE = 3'd3;
    localparam logic [2:0] ST_LSKIP = 3'd4;
    localparam logic [2:0] ST_DSIZE = 3'd5;
    localparam logic [2:0] ST_DATA  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [31:0] TAG_LIST = 32'h5453_494C;
    localparam logic [4:0]  RIFF_END = 5'd11;
    localparam logic [4:0]  FMT_END  = 5'd23;
    localparam logic [4:0]  WORD_END = 5'd3;

    logic [2:0]  stage_reg, stage_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] rem_dec;
    logic [31:0] half;
    logic        emit;
    item_t       item;

    always_comb
    begin
        stage_next = stage_reg;
        pos_next   = pos_reg + 5'd1;
        shift_next = {byte_data, shift_reg[31:8]};
        rem_next   = rem_reg;
        rem_dec    = rem_reg - 32'd1;
        half       = {16'd0, shift_next[31:16]};
        emit       = 1'b0;
        item       = '0;

        unique case (stage_reg)
            ST_RIFF:
            begin
                if (pos_reg == 5'd7)
                begin
                    emit = 1'b1;
                    item = '{KIND_RIFF_SIZE, shift_next, 1'b0};
                end
                if (pos_reg >= RIFF_END)
                begin
                    stage_next = ST_FMT;
                    pos_next   = '0;
                end
            end
            ST_FMT:
            begin
                // The 16-bit fields sit in the upper half of the shift word.
                case (pos_reg)
                    5'd9:    begin emit = 1'b1; item = '{KIND_FORMAT, half, 1'b0}; end
                    5'd11:   begin emit = 1'b1; item = '{KIND_CHANNELS, half, 1'b0}; end
                    5'd15:   begin emit = 1'b1; item = '{KIND_RATE, shift_next, 1'b0}; end
                    5'd19:   begin emit = 1'b1; item = '{KIND_BYTE_RATE, shift_next, 1'b0}; end
                    5'd21:   begin emit = 1'b1; item = '{KIND_BLOCK_ALGN, half, 1'b0}; end
                    5'd23:   begin emit = 1'b1; item = '{KIND_BITS, half, 1'b0}; end
                    default: emit = 1'b0;
                endcase
                if (pos_reg >= FMT_END)
                begin
                    stage_next = ST_TAG;
                    pos_next   = '0;
                end
            end
            ST_TAG:
            begin
                if (pos_reg >= WORD_END)
                begin
                    stage_next = (shift_next == TAG_LIST) ? ST_LSIZE : ST_DSIZE;
                    pos_next   = '0;
                end
            end
            ST_LSIZE, ST_DSIZE:
            begin
                if (pos_reg >= WORD_END)
                begin
                    emit     = 1'b1;
                    item     = '{(stage_reg == ST_LSIZE) ? KIND_LIST_SIZE : KIND_DATA_SIZE,
                                 shift_next, 1'b0};
                    rem_next = shift_next;
                    pos_next = '0;
                    if (stage_reg == ST_LSIZE)
                    begin
                        stage_next = (shift_next != '0) ? ST_LSKIP : ST_TAG;
                    end
                    else
                    begin
                        stage_next = (shift_next != '0) ? ST_DATA : ST_DONE;
                    end
                end
            end
            ST_LSKIP:
            begin
                rem_next = rem_dec;
                pos_next = '0;
                if (rem_dec == '0)
                begin
                    stage_next = ST_TAG;
                end
            end
            ST_DATA:
            begin
                rem_next = rem_dec;
                pos_next = '0;
                emit     = 1'b1;
                item     = '{KIND_SAMPLE, {24'd0, byte_data}, (rem_dec == '0)};
                if (rem_dec == '0)
                begin
                    stage_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                pos_next = '0;
            end
            default:
            begin
                pos_next = '0;
            end
        endcase

        result.emit = fire && emit;
        result.item = item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_RIFF;
            pos_reg   <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
        end
        else if (fire)
        begin
            stage_reg <= stage_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    a_sample_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result.emit && result.item.item_kind == KIND_SAMPLE) |-> stage_reg == ST_DATA)
        else $error("sample byte reported outside the data chunk");

    a_last_ends_data: assert property (@(posedge clk) disable iff (!rst_n)
        (result.emit && result.item.last_sample) |=> stage_reg == ST_DONE)
        else $error("final sample did not end the data chunk");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_DONE |-> !result.emit)
        else $error("result reported after the data chunk ended");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == ST_DONE |=> stage_reg == ST_DONE)
        else $error("parser left the done stage");

    a_counted_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == ST_LSKIP || stage_reg == ST_DATA || stage_reg == ST_DONE)
        |-> pos_reg == '0)
        else $error("byte position not cleared in a counted stage");
endmodule

`default_nettype wire

// ===== hw/rtl/wavp_out_stage.sv =====
// Output register holding one result until the downstream side takes it.
`default_nettype none

module wavp_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wavp_pkg::result_t result,
    output logic                   advance,
    wavp_item_if.source            items
);
    import wavp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The register may be refilled in the cycle its request is taken.
    assign advance = !valid_reg || items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            item_reg <= result.item;
        end
    end

    assign items.valid       = valid_reg;
    assign items.item_kind   = item_reg.item_kind;
    assign items.item_value  = item_reg.item_value;
    assign items.last_sample = item_reg.last_sample;
endmodule

`default_nettype wire

// ===== hw/rtl/wav_header_stream_parser_top.sv =====
// Top level of the WAV header stream parser.
//
//   Channel  Role   Payload                                  Request carries
//   bytes    sink   file_byte[7:0]                           one byte of the file
//   items    source item_kind[3:0] item_value[31:0] last_sample  one field or sample
//
// One byte is accepted per cycle while items does not stall; each byte is held in the input
// register and its result, if any, is then registered in the output register.
// The parse step between the two registers is a single pass of the stage machine.
// Reset clears the stage, position, shift word, counter and both valid flags.
// A stall on items holds both registers; bytes stays ready while either can move.
`default_nettype none

module wav_header_stream_parser_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wavp_byte_if.sink   bytes,
    wavp_item_if.source items
);
    import wavp_pkg::*;

    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;
    result_t    result;

    wavp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    wavp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (byte_valid && advance),
        .byte_data (byte_data),
        .result    (result)
    );

    wavp_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .advance (advance),
        .items   (items)
    );
endmodule

`default_nettype wire

// ===== sim/wav_header_stream_parser_top_tb.sv =====
// Self-checking testbench for the WAV header stream parser: one file, header fields and samples.
module wav_header_stream_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wavp_pkg::*;

    typedef enum logic [2:0] {
        STG_RIFF, STG_FMT, STG_TAG, STG_LIST_SIZE,
        STG_LIST_SKIP, STG_DATA_SIZE, STG_DATA, STG_DONE
    } stage_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] word;
        logic        typed;
        item_t       want;
    } field_row_t;

    localparam logic [31:0] LIST_TAG = 32'h5453_494C;
    localparam item_t       NO_ITEM  = '0;
    localparam int          PHASE_LEN = 70;

    logic clk;
    logic rst_n;

    wavp_byte_if byte_ch ();
    wavp_item_if item_ch ();

    wav_header_stream_parser_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .items (item_ch)
    );

    // The file header is walked field by field, each field sent little-endian.
    field_row_t header_script [0:18] = '{
        '{3'd4, 32'h4646_4952, 1'b0, NO_ITEM},
        '{3'd4, 32'hFFFF_FFFF, 1'b1, '{KIND_RIFF_SIZE, 32'hFFFF_FFFF, 1'b0}},
        '{3'd4, 32'h4556_4157, 1'b0, NO_ITEM},
        '{3'd4, 32'h2074_6D66, 1'b0, NO_ITEM},
        '{3'd4, 32'h0000_0010, 1'b0, NO_ITEM},
        '{3'd2, 32'h0000_FFFF, 1'b1, '{KIND_FORMAT, 32'h0000_FFFF, 1'b0}},
        '{3'd2, 32'h0000_0000, 1'b1, '{KIND_CHANNELS, 32'h0000_0000, 1'b0}},
        '{3'd4, 32'hFFFF_FFFF, 1'b1, '{KIND_RATE, 32'hFFFF_FFFF, 1'b0}},
        '{3'd4, 32'h0000_0000, 1'b1, '{KIND_BYTE_RATE, 32'h0000_0000, 1'b0}},
        '{3'd2, 32'h0000_FFFF, 1'b1, '{KIND_BLOCK_ALGN, 32'h0000_FFFF, 1'b0}},
        '{3'd2, 32'h0000_0000, 1'b1, '{KIND_BITS, 32'h0000_0000, 1'b0}},
        '{3'd4, LIST_TAG,      1'b0, NO_ITEM},
        '{3'd4, 32'h0000_0000, 1'b1, '{KIND_LIST_SIZE, 32'h0000_0000, 1'b0}},
        '{3'd4, LIST_TAG,      1'b0, NO_ITEM},
        '{3'd4, 32'h0000_0003, 1'b1, '{KIND_LIST_SIZE, 32'h0000_0003, 1'b0}},
        '{3'd3, 32'h0000_FF00, 1'b0, NO_ITEM},
        '{3'd4, LIST_TAG,      1'b0, NO_ITEM},
        '{3'd4, 32'h0000_0001, 1'b0, NO_ITEM},
        '{3'd1, 32'h0000_004C, 1'b0, NO_ITEM}
    };

    // Parser state mirrored by the predictor.
    stage_t      stage     = STG_RIFF;
    logic [4:0]  position  = '0;
    logic [31:0] shift_word = '0;
    logic [31:0] remaining = '0;

    item_t pending_items [$];
    int    mismatches = 0;
    int    bytes_sent = 0;
    int    idle_pct   = 0;
    int    stall_pct  = 0;
    item_t seen_want;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic item_t make_item(input logic [3:0] kind, input logic [31:0] value,
                                        input logic last);
        item_t it;
        it.item_kind   = kind;
        it.item_value  = value;
        it.last_sample = last;
        return it;
    endfunction

    task automatic parse_byte(input logic [7:0] b, output logic got, output item_t it);
        logic [4:0]  p;
        logic [31:0] half;
        p = position;
        got = 1'b0;
        it = NO_ITEM;
        shift_word = {b, shift_word[31:8]};
        half = {16'h0000, shift_word[31:16]};
        position = p + 5'd1;
        case (stage)
            STG_RIFF:
            begin
                if (p == 5'd7)
                begin
                    got = 1'b1;
                    it = make_item(KIND_RIFF_SIZE, shift_word, 1'b0);
                end
                if (p >= 5'd11)
                begin
                    stage = STG_FMT;
                    position = '0;
                end
            end
            STG_FMT:
            begin
                got = 1'b1;
                case (p)
                    5'd9:    it = make_item(KIND_FORMAT, half, 1'b0);
                    5'd11:   it = make_item(KIND_CHANNELS, half, 1'b0);
                    5'd15:   it = make_item(KIND_RATE, shift_word, 1'b0);
                    5'd19:   it = make_item(KIND_BYTE_RATE, shift_word, 1'b0);
                    5'd21:   it = make_item(KIND_BLOCK_ALGN, half, 1'b0);
                    5'd23:   it = make_item(KIND_BITS, half, 1'b0);
                    default: got = 1'b0;
                endcase
                if (p >= 5'd23)
                begin
                    stage = STG_TAG;
                    position = '0;
                end
            end
            STG_TAG:
            begin
                if (p >= 5'd3)
                begin
                    stage = (shift_word == LIST_TAG) ? STG_LIST_SIZE : STG_DATA_SIZE;
                    position = '0;
                end
            end
            STG_LIST_SIZE, STG_DATA_SIZE:
            begin
                if (p >= 5'd3)
                begin
                    got = 1'b1;
                    remaining = shift_word;
                    position = '0;
                    if (stage == STG_LIST_SIZE)
                    begin
                        it = make_item(KIND_LIST_SIZE, shift_word, 1'b0);
                        stage = (shift_word != 0) ? STG_LIST_SKIP : STG_TAG;
                    end
                    else
                    begin
                        it = make_item(KIND_DATA_SIZE, shift_word, 1'b0);
                        stage = (shift_word != 0) ? STG_DATA : STG_DONE;
                    end
                end
            end
            STG_LIST_SKIP:
            begin
                remaining = remaining - 32'd1;
                position = '0;
                if (remaining == 0)
                    stage = STG_TAG;
            end
            STG_DATA:
            begin
                remaining = remaining - 32'd1;
                position = '0;
                got = 1'b1;
                it = make_item(KIND_SAMPLE, {24'h0, b}, remaining == 0);
                if (remaining == 0)
                    stage = STG_DONE;
            end
            default:
                position = '0;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_expected(input item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input item_t want);
        logic  got;
        item_t it;
        case ((bytes_sent / PHASE_LEN) % 5)
            1:       begin idle_pct = 86; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 86; end
            3:       begin idle_pct = 29; stall_pct = 29; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
        while ($urandom_range(99) < idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.file_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        parse_byte(b, got, it);
        if (typed)
            queue_expected(want);
        else if (got)
            queue_expected(it);
        bytes_sent++;
    endtask

    task automatic send_field(input int len, input logic [31:0] word, input logic typed,
                              input item_t want);
        for (int i = 0; i < len; i++)
            send_byte(word[8*i +: 8], typed && (i == len - 1), want);
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        while (pending_items.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        item_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            if (pending_items.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d value %h",
                                          item_ch.item_kind, item_ch.item_value));
            end
            else
            begin
                seen_want = pending_items.pop_front();
                if (item_ch.item_kind !== seen_want.item_kind)
                    report_mismatch($sformatf("item_kind %0d, wanted %0d",
                                              item_ch.item_kind, seen_want.item_kind));
                if (item_ch.item_value !== seen_want.item_value)
                    report_mismatch($sformatf("item_value %h, wanted %h (kind %0d)",
                                              item_ch.item_value, seen_want.item_value,
                                              seen_want.item_kind));
                if (item_ch.last_sample !== seen_want.last_sample)
                    report_mismatch($sformatf("last_sample %b, wanted %b",
                                              item_ch.last_sample, seen_want.last_sample));
            end
        end
    end

    initial
    begin
        int          list_bytes;
        int          chunk_len;
        int          tail_len;
        logic [31:0] tag;
        logic [31:0] data_len;
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.file_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (header_script[i])
            send_field(header_script[i].len, header_script[i].word,
                       header_script[i].typed, header_script[i].want);

        // LIST chunks with random content; now and then the content itself spells LIST.
        list_bytes = 0;
        while (list_bytes < 170)
        begin
            chunk_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
            send_field(4, LIST_TAG, 1'b0, NO_ITEM);
            send_field(4, chunk_len, 1'b0, NO_ITEM);
            for (int i = 0; i < chunk_len; i++)
            begin
                if (chunk_len - i >= 4 && $urandom_range(15) == 0)
                begin
                    send_field(4, LIST_TAG, 1'b0, NO_ITEM);
                    i += 3;
                end
                else
                    send_byte(8'($urandom_range(255)), 1'b0, NO_ITEM);
            end
            list_bytes += chunk_len + 8;
        end

        // Let the block run dry before the data chunk starts.
        drain_results();

        tag = $urandom();
        while (tag == LIST_TAG)
            tag = $urandom();
        // An empty data chunk ends the file at once, so only some runs take it, and
        // those runs make up the byte count with a longer ignored tail.
        data_len = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(280, 340));
        tail_len = (data_len == 0) ? 310 : 16;
        send_field(4, tag, 1'b0, NO_ITEM);
        send_field(4, data_len, 1'b0, NO_ITEM);
        for (int i = 0; i < data_len; i++)
            send_byte(8'($urandom_range(255)), 1'b0, NO_ITEM);
        for (int i = 0; i < tail_len; i++)
            send_byte(8'($urandom_range(255)), 1'b0, NO_ITEM);

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("TIMEOUT at %0t ns", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule
